FILE: rtl/frame_header_classifier_unit_macros.svh
// ----------------------------------------------------------------------------
// Frame header classifier assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef FRAME_HEADER_CLASSIFIER_UNIT_MACROS_SVH
`define FRAME_HEADER_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication.
`define FHC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fhc_pkg.sv
// ----------------------------------------------------------------------------
// Frame header classifier package
// Types, codes and constants shared by the classifier modules.
// ----------------------------------------------------------------------------
package fhc_pkg;

  localparam int MAX_FRAME_DEF = 2048;

  localparam logic [15:0] TCP_PORT_RESET = 16'd443;
  localparam logic [15:0] UDP_PORT_RESET = 16'd53;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // Register select bit (byte address bit 2)
  localparam logic REG_TCP_PORT = 1'b0;
  localparam logic REG_UDP_PORT = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT     = 3'd0,
    VERDICT_ETHERTYPE  = 3'd1,
    VERDICT_PROTOCOL   = 3'd2,
    VERDICT_EMPTY      = 3'd3,
    VERDICT_MISMATCH   = 3'd4,
    VERDICT_TRUNCATED  = 3'd5,
    VERDICT_TOO_LONG   = 3'd6
  } verdict_t;

  typedef enum logic [1:0] {
    TRANSPORT_NONE = 2'd0,
    TRANSPORT_TCP  = 2'd1,
    TRANSPORT_UDP  = 2'd2
  } transport_t;

  // Header fields gathered over one frame
  typedef struct packed {
    logic [15:0] ether_kind;
    logic [7:0]  l4_start;
    logic [7:0]  l4_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [3:0]  tcp_header_words;
    logic        overflow;
  } hdr_t;

  typedef struct packed {
    verdict_t    verdict;
    transport_t  transport;
    logic [7:0]  payload_offset;
    logic [11:0] payload_length;
  } result_t;

endpackage

FILE: rtl/fhc_capture.sv
// ----------------------------------------------------------------------------
// Frame header capture
// Counts frame bytes, picks header fields by position and hands a snapshot
// of the finished frame to the decision stage on its last byte.
// ----------------------------------------------------------------------------
module fhc_capture #(
  parameter int MAX_FRAME = fhc_pkg::MAX_FRAME_DEF,
  parameter int CW        = $clog2(MAX_FRAME + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       data_byte,
  input  logic             last,
  input  logic             snap_take,
  output logic             snap_valid,
  output fhc_pkg::hdr_t    snap_hdr,
  output logic [CW-1:0]    snap_len
);

  localparam int LW = (CW > 8) ? CW : 8;

  localparam int IDX_TYPE_HI  = 12;
  localparam int IDX_TYPE_LO  = 13;
  localparam int IDX_IHL      = 14;
  localparam int IDX_V6_NEXT  = 20;
  localparam int IDX_V4_PROTO = 23;
  localparam logic [7:0] L4_START_V6 = 8'd54;
  localparam logic [7:0] ETH_HDR_LEN = 8'd14;

  logic [CW-1:0]  byte_count, byte_count_next;
  fhc_pkg::hdr_t  hdr, hdr_next;

  logic           ovf_now, is_v4, is_v6, past_eth;
  logic [15:0]    type_lo;
  logic [7:0]     start_v4, start_eff;
  logic [LW-1:0]  idx_w, start_w, rel;
  logic           in_l4;

  assign ovf_now   = byte_count >= CW'(MAX_FRAME);
  assign is_v4     = hdr.ether_kind == fhc_pkg::ETH_IPV4;
  assign is_v6     = hdr.ether_kind == fhc_pkg::ETH_IPV6;
  assign past_eth  = byte_count >= CW'(IDX_IHL);
  assign type_lo   = {hdr.ether_kind[15:8], data_byte};
  assign start_v4  = ETH_HDR_LEN + {2'b00, data_byte[3:0], 2'b00};
  assign start_eff = (is_v4 && byte_count == CW'(IDX_IHL)) ? start_v4 : hdr.l4_start;
  assign idx_w     = LW'(byte_count);
  assign start_w   = LW'(start_eff);
  assign rel       = idx_w - start_w;
  assign in_l4     = idx_w >= start_w;

  always_comb begin
    hdr_next        = hdr;
    byte_count_next = byte_count;
    if (ovf_now) begin
      hdr_next.overflow = 1'b1;
    end else begin
      byte_count_next = byte_count + CW'(1);
      if (byte_count == CW'(IDX_TYPE_HI)) begin
        hdr_next.ether_kind = {data_byte, 8'h00};
      end
      if (byte_count == CW'(IDX_TYPE_LO)) begin
        hdr_next.ether_kind = type_lo;
        if (type_lo == fhc_pkg::ETH_IPV6) begin
          hdr_next.l4_start = L4_START_V6;
        end
      end
      if (past_eth && (is_v4 || is_v6)) begin
        if (is_v4 && byte_count == CW'(IDX_IHL)) begin
          hdr_next.l4_start = start_v4;
        end
        if ((is_v4 && byte_count == CW'(IDX_V4_PROTO)) ||
            (is_v6 && byte_count == CW'(IDX_V6_NEXT))) begin
          hdr_next.l4_protocol = data_byte;
        end
        if (in_l4) begin
          unique case (rel)
            LW'(0):  hdr_next.source_port[15:8] = data_byte;
            LW'(1):  hdr_next.source_port[7:0]  = data_byte;
            LW'(2):  hdr_next.dest_port[15:8]   = data_byte;
            LW'(3):  hdr_next.dest_port[7:0]    = data_byte;
            LW'(12): hdr_next.tcp_header_words  = data_byte[7:4];
            default: ;
          endcase
        end
      end
    end
  end

  // Frame state: clear on the last byte so the next byte opens a new frame
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      hdr        <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (advance) begin
        if (last) begin
          byte_count <= '0;
          hdr        <= '0;
        end else begin
          byte_count <= byte_count_next;
          hdr        <= hdr_next;
        end
      end
      if (advance && last) begin
        snap_valid <= 1'b1;
      end else if (snap_take) begin
        snap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last) begin
      snap_hdr <= hdr_next;
      snap_len <= byte_count_next;
    end
  end

endmodule

FILE: rtl/fhc_decide.sv
// ----------------------------------------------------------------------------
// Frame verdict logic
// Turns a frame snapshot and the match ports into one classification result.
// ----------------------------------------------------------------------------
module fhc_decide #(
  parameter int CW = 12
) (
  input  fhc_pkg::hdr_t     hdr,
  input  logic [CW-1:0]     len,
  input  logic [15:0]       tcp_match_port,
  input  logic [15:0]       udp_match_port,
  output fhc_pkg::result_t  res
);

  localparam int LW = (CW > 12) ? CW : 12;

  localparam int MIN_ETH  = 14;
  localparam int MIN_V4   = 24;
  localparam int MIN_V6   = 21;
  localparam int TCP_NEED = 13;
  localparam int UDP_HDR  = 8;

  logic           is_v4, is_v6, is_tcp, is_udp;
  logic [LW-1:0]  len_w, start_w, need, poff, plen;
  logic [15:0]    port;

  assign is_v4   = hdr.ether_kind == fhc_pkg::ETH_IPV4;
  assign is_v6   = hdr.ether_kind == fhc_pkg::ETH_IPV6;
  assign is_tcp  = hdr.l4_protocol == fhc_pkg::PROTO_TCP;
  assign is_udp  = hdr.l4_protocol == fhc_pkg::PROTO_UDP;
  assign len_w   = LW'(len);
  assign start_w = LW'(hdr.l4_start);
  assign need    = start_w + (is_tcp ? LW'(TCP_NEED) : LW'(UDP_HDR));
  assign poff    = start_w + (is_tcp ? LW'({hdr.tcp_header_words, 2'b00}) : LW'(UDP_HDR));
  assign plen    = len_w - poff;
  assign port    = is_tcp ? tcp_match_port : udp_match_port;

  always_comb begin
    res = '{verdict: fhc_pkg::VERDICT_ACCEPT, transport: fhc_pkg::TRANSPORT_NONE,
            payload_offset: 8'd0, payload_length: 12'd0};
    priority if (hdr.overflow) begin
      res.verdict = fhc_pkg::VERDICT_TOO_LONG;
    end else if (len_w < LW'(MIN_ETH)) begin
      res.verdict = fhc_pkg::VERDICT_TRUNCATED;
    end else if (!is_v4 && !is_v6) begin
      res.verdict = fhc_pkg::VERDICT_ETHERTYPE;
    end else if (len_w < (is_v4 ? LW'(MIN_V4) : LW'(MIN_V6))) begin
      res.verdict = fhc_pkg::VERDICT_TRUNCATED;
    end else if (!is_tcp && !is_udp) begin
      res.verdict = fhc_pkg::VERDICT_PROTOCOL;
    end else if (len_w < need || len_w < poff) begin
      res.verdict = fhc_pkg::VERDICT_TRUNCATED;
    end else begin
      res.transport      = is_tcp ? fhc_pkg::TRANSPORT_TCP : fhc_pkg::TRANSPORT_UDP;
      res.payload_offset = poff[7:0];
      res.payload_length = plen[11:0];
      priority if (plen == '0) begin
        res.verdict = fhc_pkg::VERDICT_EMPTY;
      end else if (hdr.source_port != port && hdr.dest_port != port) begin
        res.verdict = fhc_pkg::VERDICT_MISMATCH;
      end else begin
        res.verdict = fhc_pkg::VERDICT_ACCEPT;
      end
    end
  end

endmodule

FILE: rtl/frame_header_classifier_unit.sv
// ----------------------------------------------------------------------------
// Frame header classifier
// Classifies an Ethernet frame, fed one byte per beat from the destination
// MAC onwards, by EtherType, IPv4/IPv6 transport protocol and TCP/UDP port.
// It takes one byte every cycle, whatever the frame length, unless a held
// result stalls a last byte. No result is produced for a byte unless it
// carries tlast; the last byte of a frame gives exactly one result beat on the
// master side. Each byte passes an input register, then the capture stage
// (byte counter and positional field pick-up, one byte per cycle), then a
// frame snapshot that the verdict logic turns into the result register. A
// stalled result holds the snapshot behind it, and only then does the slave
// side stop, on the next last byte; ordinary bytes keep flowing. The match
// ports are to be written over the APB port only while the block is idle;
// the block does not enforce it: tcp_match_port at 0x0, udp_match_port at 0x4.
// ----------------------------------------------------------------------------
module frame_header_classifier_unit #(
  parameter int MAX_FRAME = fhc_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [2:0] verdict, [4:3] transport,
                                 // [12:5] payload_offset, [24:13] payload_length
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_FRAME + 1);

  // Configuration registers
  logic [15:0] tcp_match_port;
  logic [15:0] udp_match_port;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tcp_match_port <= fhc_pkg::TCP_PORT_RESET;
      udp_match_port <= fhc_pkg::UDP_PORT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        fhc_pkg::REG_TCP_PORT: tcp_match_port <= pwdata[15:0];
        fhc_pkg::REG_UDP_PORT: udp_match_port <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fhc_pkg::REG_TCP_PORT: prdata = {16'd0, tcp_match_port};
      fhc_pkg::REG_UDP_PORT: prdata = {16'd0, udp_match_port};
      default:               prdata = '0;
    endcase
  end

  // Input register: one beat deep
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic       in_load;

  logic               snap_valid;
  logic               snap_take;
  fhc_pkg::hdr_t      snap_hdr;
  logic [CW-1:0]      snap_len;

  // Result register
  logic              out_valid;
  fhc_pkg::result_t  out_res;
  fhc_pkg::result_t  res;
  logic              out_rejected;

  // Move the snapshot on when the result register is empty or being drained
  assign snap_take = snap_valid && (!out_valid || m_tready);

  // Plain bytes always advance; a last byte waits for a free snapshot slot
  assign advance  = in_valid && (!in_last || !snap_valid || snap_take);
  assign s_tready = !in_valid || advance;
  assign in_load  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  fhc_capture #(
    .MAX_FRAME (MAX_FRAME),
    .CW        (CW)
  ) u_capture (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .data_byte  (in_byte),
    .last       (in_last),
    .snap_take  (snap_take),
    .snap_valid (snap_valid),
    .snap_hdr   (snap_hdr),
    .snap_len   (snap_len)
  );

  fhc_decide #(
    .CW (CW)
  ) u_decide (
    .hdr            (snap_hdr),
    .len            (snap_len),
    .tcp_match_port (tcp_match_port),
    .udp_match_port (udp_match_port),
    .res            (res)
  );

  // Hold the result until the master side takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_take) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res.payload_length, out_res.payload_offset,
                     out_res.transport, out_res.verdict};

  // Verdicts decided before the transport checks
  assign out_rejected = out_res.verdict == fhc_pkg::VERDICT_TOO_LONG ||
                        out_res.verdict == fhc_pkg::VERDICT_TRUNCATED ||
                        out_res.verdict == fhc_pkg::VERDICT_ETHERTYPE ||
                        out_res.verdict == fhc_pkg::VERDICT_PROTOCOL;

`include "frame_header_classifier_unit_macros.svh"

  // A last byte never lands on a snapshot that is still waiting
  `FHC_ASSERT_SAME(a_snap_no_overwrite, advance && in_last && snap_valid, snap_take, "snapshot overwritten")

  // A snapshot that moves on always shows up as a result beat
  `FHC_ASSERT_NEXT(a_snap_to_result, snap_take, out_valid, "snapshot lost before result register")

  // Only verdicts past the header checks carry transport details
  `FHC_ASSERT_SAME(a_transport_consistent, out_valid && out_rejected, out_res.transport == fhc_pkg::TRANSPORT_NONE && out_res.payload_offset == 8'd0 && out_res.payload_length == 12'd0, "rejected frame carries transport fields")

endmodule

FILE: dv/frame_header_classifier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame header classifier testbench
// Feeds Ethernet frames byte by byte into the classifier and checks every
// verdict beat against the typed verdict or an in-bench model of the header
// pick-up and decision. A short table of hand-built frames comes first, then
// random frames (mostly well-formed IPv4/IPv6 TCP/UDP headers, some noise)
// under four idling phases, with match ports rewritten over APB between phases.
// ----------------------------------------------------------------------------
module frame_header_classifier_unit_tb;
  import fhc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;     // pipeline is three stages deep
  localparam int PHASE_BYTES = 363;     // about 1450 random bytes over four phases
  localparam int PHASE_FRAMES = 16;

  // One frame as the stimulus sees it: header fields placed at their offsets,
  // random bytes elsewhere. chk set means the verdict below is taken as typed.
  typedef struct packed {
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  doff;
    logic [11:0] len;
    logic        chk;
    result_t     exp;
  } frame_row_t;

  localparam result_t NIL_RES   = '{VERDICT_ACCEPT, TRANSPORT_NONE, 8'd0, 12'd0};
  localparam result_t TRUNC_RES = '{VERDICT_TRUNCATED, TRANSPORT_NONE, 8'd0, 12'd0};
  localparam result_t ETYPE_RES = '{VERDICT_ETHERTYPE, TRANSPORT_NONE, 8'd0, 12'd0};
  localparam result_t PROTO_RES = '{VERDICT_PROTOCOL, TRANSPORT_NONE, 8'd0, 12'd0};
  localparam result_t LONG_RES  = '{VERDICT_TOO_LONG, TRANSPORT_NONE, 8'd0, 12'd0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
  logic        s_tlast = 1'b0;   // last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [2:0] verdict, [4:3] transport,
                                 // [12:5] payload_offset, [24:13] payload_length
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Match ports as the block should hold them
  logic [15:0] tcp_port_cfg = TCP_PORT_RESET;
  logic [15:0] udp_port_cfg = UDP_PORT_RESET;

  // Per-frame header state of the classifier
  logic [11:0] frm_count = '0;
  logic [15:0] frm_ether = '0;
  logic [7:0]  frm_l4 = '0;
  logic [7:0]  frm_proto = '0;
  logic [15:0] frm_sport = '0;
  logic [15:0] frm_dport = '0;
  logic [3:0]  frm_words = '0;
  logic        frm_over = 1'b0;

  result_t     pending_verdicts[$];
  logic [7:0]  frame_buf[];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          fail_count = 0;
  int          cycle_count = 0;

  // Hand-built frames. Typed verdicts where the answer is plain; the rest
  // (small IHL and data offset, port extremes) go through the model.
  frame_row_t directed_rows [24] = '{
    // one byte, and one short of the EtherType
    '{ETH_IPV4, 4'd5, PROTO_TCP, 16'd443, 16'd443, 4'd5, 12'd1, 1'b1, TRUNC_RES},
    '{ETH_IPV4, 4'd5, PROTO_TCP, 16'd443, 16'd443, 4'd5, 12'd13, 1'b1, TRUNC_RES},
    // foreign EtherTypes, including both extremes
    '{16'h1234, 4'd5, PROTO_TCP, 16'd443, 16'd443, 4'd5, 12'd14, 1'b1, ETYPE_RES},
    '{16'hFFFF, 4'd5, PROTO_UDP, 16'd53, 16'd53, 4'd5, 12'd60, 1'b1, ETYPE_RES},
    '{16'h0000, 4'd5, PROTO_UDP, 16'd53, 16'd53, 4'd5, 12'd14, 1'b1, ETYPE_RES},
    // protocol byte missing
    '{ETH_IPV4, 4'd5, PROTO_TCP, 16'd443, 16'd443, 4'd5, 12'd23, 1'b1, TRUNC_RES},
    '{ETH_IPV6, 4'd5, PROTO_TCP, 16'd443, 16'd443, 4'd5, 12'd20, 1'b1, TRUNC_RES},
    // foreign transport protocols
    '{ETH_IPV4, 4'd5, 8'd1, 16'd443, 16'd443, 4'd5, 12'd24, 1'b1, PROTO_RES},
    '{ETH_IPV6, 4'd5, 8'hFF, 16'd53, 16'd53, 4'd5, 12'd60, 1'b1, PROTO_RES},
    // empty payload, accept, port mismatch
    '{ETH_IPV4, 4'd5, PROTO_TCP, 16'd443, 16'd1, 4'd5, 12'd54, 1'b1,
      '{VERDICT_EMPTY, TRANSPORT_TCP, 8'd54, 12'd0}},
    '{ETH_IPV4, 4'd5, PROTO_TCP, 16'd7, 16'd443, 4'd5, 12'd64, 1'b1,
      '{VERDICT_ACCEPT, TRANSPORT_TCP, 8'd54, 12'd10}},
    '{ETH_IPV4, 4'd5, PROTO_TCP, 16'd1, 16'd2, 4'd5, 12'd64, 1'b1,
      '{VERDICT_MISMATCH, TRANSPORT_TCP, 8'd54, 12'd10}},
    '{ETH_IPV4, 4'd5, PROTO_UDP, 16'd53, 16'd9, 4'd5, 12'd50, 1'b1,
      '{VERDICT_ACCEPT, TRANSPORT_UDP, 8'd42, 12'd8}},
    '{ETH_IPV6, 4'd5, PROTO_UDP, 16'd9, 16'd53, 4'd5, 12'd70, 1'b1,
      '{VERDICT_ACCEPT, TRANSPORT_UDP, 8'd62, 12'd8}},
    // largest headers
    '{ETH_IPV6, 4'd5, PROTO_TCP, 16'd443, 16'd0, 4'd15, 12'd120, 1'b1,
      '{VERDICT_ACCEPT, TRANSPORT_TCP, 8'd114, 12'd6}},
    '{ETH_IPV4, 4'd15, PROTO_TCP, 16'd443, 16'd0, 4'd15, 12'd140, 1'b1,
      '{VERDICT_ACCEPT, TRANSPORT_TCP, 8'd134, 12'd6}},
    // L4 header cut short
    '{ETH_IPV4, 4'd5, PROTO_TCP, 16'd443, 16'd443, 4'd5, 12'd50, 1'b1, TRUNC_RES},
    '{ETH_IPV4, 4'd5, PROTO_UDP, 16'd53, 16'd53, 4'd5, 12'd41, 1'b1, TRUNC_RES},
    // small data offset and small IHL: fields overlap, model decides
    '{ETH_IPV4, 4'd5, PROTO_TCP, 16'd443, 16'd5, 4'd0, 12'd47, 1'b0, NIL_RES},
    '{ETH_IPV4, 4'd0, PROTO_TCP, 16'd443, 16'd443, 4'd5, 12'd40, 1'b0, NIL_RES},
    '{ETH_IPV4, 4'd1, PROTO_UDP, 16'hFFFF, 16'h0000, 4'd2, 12'd36, 1'b0, NIL_RES},
    '{ETH_IPV6, 4'd5, PROTO_TCP, 16'hFFFF, 16'hFFFF, 4'd3, 12'd80, 1'b0, NIL_RES},
    // longest frame, then one byte over
    '{ETH_IPV4, 4'd5, PROTO_UDP, 16'd53, 16'd53, 4'd5, 12'd2048, 1'b1,
      '{VERDICT_ACCEPT, TRANSPORT_UDP, 8'd42, 12'd2006}},
    '{ETH_IPV4, 4'd5, PROTO_UDP, 16'd53, 16'd53, 4'd5, 12'd2049, 1'b1, LONG_RES}
  };

  frame_header_classifier_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Advance the header model by one accepted byte. Returns 1 with the verdict
  // when the byte closes the frame.
  function automatic bit classify_byte(input logic [7:0] b, input logic lst,
                                       output result_t r);
    int idx;
    int rel;
    int len;
    int need;
    int poff;
    bit is_tcp;
    logic [15:0] port;
    r = NIL_RES;
    if (frm_count >= 12'(MAX_FRAME_DEF)) begin
      frm_over = 1'b1;
    end else begin
      idx = int'(frm_count);
      if (idx == 12) frm_ether = {b, 8'h00};
      if (idx == 13) begin
        frm_ether[7:0] = b;
        if (frm_ether == ETH_IPV6) frm_l4 = 8'd54;
      end
      if (idx >= 14 && (frm_ether == ETH_IPV4 || frm_ether == ETH_IPV6)) begin
        if (frm_ether == ETH_IPV4) begin
          if (idx == 14) frm_l4 = 8'(14 + 4 * int'(b[3:0]));
          if (idx == 23) frm_proto = b;
        end else if (idx == 20) begin
          frm_proto = b;
        end
        // ports and data offset are picked up by position from the L4 start
        rel = idx - int'(frm_l4);
        case (rel)
          0:  frm_sport[15:8] = b;
          1:  frm_sport[7:0] = b;
          2:  frm_dport[15:8] = b;
          3:  frm_dport[7:0] = b;
          12: frm_words = b[7:4];
          default: ;
        endcase
      end
      frm_count = frm_count + 12'd1;
    end
    if (!lst) return 1'b0;

    len = int'(frm_count);
    if (frm_over) begin
      r.verdict = VERDICT_TOO_LONG;
    end else if (len < 14) begin
      r.verdict = VERDICT_TRUNCATED;
    end else if (frm_ether != ETH_IPV4 && frm_ether != ETH_IPV6) begin
      r.verdict = VERDICT_ETHERTYPE;
    end else if (len < ((frm_ether == ETH_IPV4) ? 24 : 21)) begin
      r.verdict = VERDICT_TRUNCATED;
    end else if (frm_proto != PROTO_TCP && frm_proto != PROTO_UDP) begin
      r.verdict = VERDICT_PROTOCOL;
    end else begin
      is_tcp = (frm_proto == PROTO_TCP);
      need = int'(frm_l4) + (is_tcp ? 13 : 8);
      poff = int'(frm_l4) + (is_tcp ? 4 * int'(frm_words) : 8);
      port = is_tcp ? tcp_port_cfg : udp_port_cfg;
      if (len < need || len < poff) begin
        r.verdict = VERDICT_TRUNCATED;
      end else begin
        r.transport = is_tcp ? TRANSPORT_TCP : TRANSPORT_UDP;
        r.payload_offset = 8'(poff);
        r.payload_length = 12'(len - poff);
        if (len == poff) r.verdict = VERDICT_EMPTY;
        else if (frm_sport != port && frm_dport != port) r.verdict = VERDICT_MISMATCH;
        else r.verdict = VERDICT_ACCEPT;
      end
    end

    // the next byte opens a fresh frame
    frm_count = '0;
    frm_ether = '0;
    frm_l4 = '0;
    frm_proto = '0;
    frm_sport = '0;
    frm_dport = '0;
    frm_words = '0;
    frm_over = 1'b0;
    return 1'b1;
  endfunction

  // Mostly well-formed headers with random content; one in five is noise.
  function automatic frame_row_t random_frame();
    frame_row_t f;
    int roll;
    int l4;
    int need;
    int poff;
    int len;
    logic [15:0] mport;
    f = '0;
    f.exp = NIL_RES;
    f.sport = 16'($urandom);
    f.dport = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 80) begin
      f.etype = ($urandom_range(1) == 1) ? ETH_IPV4 : ETH_IPV6;
      f.ihl = ($urandom_range(99) < 85) ? 4'd5 : 4'($urandom_range(15));
      roll = $urandom_range(99);
      f.proto = (roll < 45) ? PROTO_TCP : (roll < 90) ? PROTO_UDP : 8'($urandom);
      f.doff = ($urandom_range(99) < 80) ? 4'($urandom_range(15, 5)) : 4'($urandom_range(15));
      // give about three frames in five a matching port on one side
      mport = (f.proto == PROTO_TCP) ? tcp_port_cfg : udp_port_cfg;
      if ($urandom_range(99) < 60) begin
        if ($urandom_range(1) == 1) f.sport = mport;
        else f.dport = mport;
      end
      l4 = (f.etype == ETH_IPV6) ? 54 : 14 + 4 * int'(f.ihl);
      need = l4 + ((f.proto == PROTO_TCP) ? 13 : 8);
      poff = (f.proto == PROTO_TCP) ? l4 + 4 * int'(f.doff) : l4 + 8;
      len = (need > poff) ? need : poff;
      if (len < 24) len = 24;
      len = len + $urandom_range(20);
      // cut some frames short
      if ($urandom_range(99) < 10) len = len - $urandom_range(8, 1);
      f.len = 12'(len);
    end else begin
      f.etype = 16'($urandom);
      if (roll < 88) f.etype = ($urandom_range(1) == 1) ? ETH_IPV4 : ETH_IPV6;
      f.ihl = 4'($urandom);
      f.proto = 8'($urandom);
      f.doff = 4'($urandom);
      f.len = 12'($urandom_range(80, 1));
    end
    return f;
  endfunction

  function automatic void put_byte(input int idx, input logic [7:0] v);
    if (idx < frame_buf.size()) frame_buf[idx] = v;
  endfunction

  // Hand one byte over as a beat; the predictor sees it once it is taken.
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input result_t typed_res);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (classify_byte(b, lst, r)) pending_verdicts.push_back(typed ? typed_res : r);
  endtask

  // Build the frame bytes: random fill, then L4 fields, then the IP header
  // fields on top so that overlapping positions keep the IHL and protocol.
  task automatic send_frame(input frame_row_t f);
    int l4;
    frame_buf = new[int'(f.len)];
    foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
    l4 = (f.etype == ETH_IPV6) ? 54 : 14 + 4 * int'(f.ihl);
    put_byte(l4, f.sport[15:8]);
    put_byte(l4 + 1, f.sport[7:0]);
    put_byte(l4 + 2, f.dport[15:8]);
    put_byte(l4 + 3, f.dport[7:0]);
    put_byte(l4 + 12, {f.doff, 4'($urandom)});
    if (f.etype == ETH_IPV6) begin
      put_byte(20, f.proto);
    end else begin
      put_byte(14, {4'h4, f.ihl});
      put_byte(23, f.proto);
    end
    put_byte(12, f.etype[15:8]);
    put_byte(13, f.etype[7:0]);
    foreach (frame_buf[i]) begin
      send_byte(frame_buf[i], (i == frame_buf.size() - 1), f.chk, f.exp);
    end
  endtask

  // Setup phase, access phase, then the bus released before the task returns, so
  // that back-to-back calls never drive psel twice in one step.
  task automatic apb_access(input logic wr, input logic reg_sel, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {reg_sel, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_port_reg(input logic reg_sel, input logic [15:0] want);
    logic [31:0] rd;
    apb_access(1'b0, reg_sel, 32'd0, rd);
    if (rd[15:0] !== want) begin
      $error("prdata: expected %0d, got %0d", want, rd[15:0]);
      fail_count++;
    end
  endtask

  task automatic write_port_reg(input logic reg_sel, input logic [15:0] val);
    logic [31:0] rd;
    apb_access(1'b1, reg_sel, {16'd0, val}, rd);
    if (reg_sel == REG_TCP_PORT) tcp_port_cfg = val;
    else udp_port_cfg = val;
    check_port_reg(reg_sel, val);
  endtask

  // Drop valid, wait for every verdict to drain, then let the pipe empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: stall at random and check each verdict beat against the oldest
  // expectation.
  always @(posedge clk) begin : verdict_monitor
    result_t want;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected verdict beat: m_tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tdata[2:0] !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, m_tdata[2:0]);
          fail_count++;
        end
        if (m_tdata[4:3] !== want.transport) begin
          $error("transport: expected %0d, got %0d", want.transport, m_tdata[4:3]);
          fail_count++;
        end
        if (m_tdata[12:5] !== want.payload_offset) begin
          $error("payload_offset: expected %0d, got %0d", want.payload_offset,
                 m_tdata[12:5]);
          fail_count++;
        end
        if (m_tdata[24:13] !== want.payload_length) begin
          $error("payload_length: expected %0d, got %0d", want.payload_length,
                 m_tdata[24:13]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int send_pcts [4];
    int recv_pcts [4];
    int phase_bytes;
    int phase_frames;
    frame_row_t f;
    send_pcts = '{0, 57, 0, 27};
    recv_pcts = '{0, 0, 57, 27};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // match ports must come out of reset at their defaults
    check_port_reg(REG_TCP_PORT, TCP_PORT_RESET);
    check_port_reg(REG_UDP_PORT, UDP_PORT_RESET);

    foreach (directed_rows[i]) send_frame(directed_rows[i]);

    for (int p = 0; p < 4; p++) begin
      settle();
      send_idle_pct = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      // extremes first, then arbitrary ports
      case (p)
        0: begin
          write_port_reg(REG_TCP_PORT, 16'h0000);
          write_port_reg(REG_UDP_PORT, 16'hFFFF);
        end
        1: begin
          write_port_reg(REG_TCP_PORT, 16'hFFFF);
          write_port_reg(REG_UDP_PORT, 16'h0000);
        end
        default: begin
          write_port_reg(REG_TCP_PORT, 16'($urandom));
          write_port_reg(REG_UDP_PORT, 16'($urandom));
        end
      endcase
      phase_bytes = 0;
      phase_frames = 0;
      while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
        f = random_frame();
        send_frame(f);
        phase_bytes += int'(f.len);
        phase_frames++;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/fhc_pkg.sv
rtl/fhc_capture.sv
rtl/fhc_decide.sv
rtl/frame_header_classifier_unit.sv
dv/frame_header_classifier_unit_tb.sv
